### hw/rtl/ara_pkg.sv
package ara_pkg;

   localparam int MAX_RANGES_DEF  = 64;
   localparam int SPACE_COUNT_DEF = 4;

   localparam logic [31:0] LIMIT_A16 = 32'h0000_ffff;
   localparam logic [31:0] LIMIT_A24 = 32'h00ff_ffff;
   localparam logic [31:0] LIMIT_A32 = 32'hffff_ffff;
   localparam logic [31:0] LIMIT_ISA = 32'h00ff_ffff;

   typedef enum logic [1:0] {
      SPACE_A16 = 2'd0,
      SPACE_A24 = 2'd1,
      SPACE_A32 = 2'd2,
      SPACE_ISA = 2'd3
   } space_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_UNKNOWN_TYPE = 3'd1,
      ST_BAD_RANGE    = 3'd2,
      ST_OVERLAP      = 3'd3,
      ST_NOT_FOUND    = 3'd4,
      ST_WRONG_OWNER  = 3'd5,
      ST_TABLE_FULL   = 3'd6
   } status_type;

   typedef enum logic {
      ACT_REGISTER = 1'b0,
      ACT_RELEASE  = 1'b1
   } action_type;

   typedef struct packed {
      logic        action;
      logic [2:0]  addr_type;
      logic [31:0] base_address;
      logic [32:0] range_size;
      logic [7:0]  owner_id;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] range_end;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
   } free_ent_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic [7:0]  owner;
   } used_ent_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CHECK,
      S_FS_RD, S_FS_EV, S_RG_FREE,
      S_FD_RD, S_FD_WR, S_FU_RD, S_FU_WR, S_F_PUT,
      S_US_RD, S_US_EV, S_UU_RD, S_UU_WR, S_U_PUT,
      S_UF_RD, S_UF_EV, S_FP_RD, S_FP_EV, S_RL_DEC,
      S_UD_RD, S_UD_WR, S_RL_FREE, S_RESP
   } state_type;

   function automatic logic [31:0] space_limit(input logic [1:0] s);
      logic [31:0] lim;
      unique case (space_type'(s))
         SPACE_A16: lim = LIMIT_A16;
         SPACE_A24: lim = LIMIT_A24;
         SPACE_A32: lim = LIMIT_A32;
         SPACE_ISA: lim = LIMIT_ISA;
         default:   lim = LIMIT_A16;
      endcase
      return lim;
   endfunction

endpackage

### hw/rtl/ara_ram.sv
module ara_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/address_range_allocator.sv
// Address range allocator: four address spaces (A16, A24, A32, ISA), each with an
// address-sorted free table and an allocated table of MAX_RANGES entries held in
// RAM. A register word finds the free range holding it, takes it whole, trims it
// or splits it and records the range with its owner; a release word finds the
// range by its start, checks the owner and merges it into its free neighbors or
// inserts it in the free table. One word is handled at a time; req_stall is high
// until its result has been taken. The single read port of each table RAM sets
// the pace: every table entry scanned or moved passes through a read state and
// then an evaluate or write state (register: free scan, free shift, used search,
// used shift; release: used search, free search, used shift, free shift). After
// reset an init pass loads the first free entry of each space before the first
// word is taken.
module address_range_allocator
   import ara_pkg::*;
#(
   parameter int MAX_RANGES  = MAX_RANGES_DEF,
   parameter int SPACE_COUNT = SPACE_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int SW = (SPACE_COUNT > 1) ? $clog2(SPACE_COUNT) : 1;
   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int AW = SW + IW;
   localparam int DEPTH = 2 ** AW;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
   localparam logic [SW-1:0] SP_LAST = SW'(SPACE_COUNT - 1);

   state_type     state_ff, state_in;
   req_word_type  req_ff, req_in;
   logic [31:0]   rend_ff, rend_in;
   logic [CW-1:0] k_ff, k_in, p_ff, p_in;
   logic [SW-1:0] sp_ff, sp_in;
   free_ent_type  cur_ff, cur_in, prv_ff, prv_in, put_ff, put_in;
   logic [31:0]   ue_ff, ue_in;
   logic          mp_ff, mp_in, mn_ff, mn_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   end_ff, end_in;
   logic [CW-1:0] fcnt_ff [SPACE_COUNT];
   logic [CW-1:0] fcnt_in [SPACE_COUNT];
   logic [CW-1:0] ucnt_ff [SPACE_COUNT];
   logic [CW-1:0] ucnt_in [SPACE_COUNT];

   logic          f_we, u_we;
   logic [AW-1:0] f_wa, f_ra, u_wa, u_ra;
   free_ent_type  f_wd, f_rd;
   used_ent_type  u_wd, u_rd;
   logic [63:0]   f_rd_raw;
   logic [71:0]   u_rd_raw;

   ara_ram #(.WIDTH(64), .DEPTH(DEPTH), .AW(AW)) u_free_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd_raw)
   );

   ara_ram #(.WIDTH(72), .DEPTH(DEPTH), .AW(AW)) u_used_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_addr(u_ra), .rd_data(u_rd_raw)
   );

   assign f_rd = free_ent_type'(f_rd_raw);
   assign u_rd = used_ent_type'(u_rd_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sp_ff    <= '0;
         for (int s = 0; s < SPACE_COUNT; s++) begin
            fcnt_ff[s] <= CW'(1);
            ucnt_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         fcnt_ff  <= fcnt_in;
         ucnt_ff  <= ucnt_in;
      end
      req_ff    <= req_in;
      rend_ff   <= rend_in;
      k_ff      <= k_in;
      p_ff      <= p_in;
      cur_ff    <= cur_in;
      prv_ff    <= prv_in;
      put_ff    <= put_in;
      ue_ff     <= ue_in;
      mp_ff     <= mp_in;
      mn_ff     <= mn_in;
      status_ff <= status_in;
      end_ff    <= end_in;
   end

   logic [SW-1:0] rs;
   logic [CW-1:0] nf, nu, km1;
   logic [CW:0]   kp1;
   logic [31:0]   lim;
   logic [33:0]   sum;
   logic [32:0]   e_inc, pe_inc;
   logic          rel;

   assign rs  = req_ff.addr_type[SW-1:0];
   assign nf  = fcnt_ff[rs];
   assign nu  = ucnt_ff[rs];
   assign km1 = k_ff - 1'b1;
   assign kp1 = {1'b0, k_ff} + 1'b1;
   assign lim = space_limit(2'(rs));
   assign sum = {2'b0, req_ff.base_address} + {1'b0, req_ff.range_size} - 34'd1;
   assign e_inc  = {1'b0, ue_ff} + 33'd1;
   assign pe_inc = {1'b0, prv_ff.hi} + 33'd1;
   assign rel = (req_ff.action == ACT_RELEASE);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      rend_in   = rend_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      sp_in     = sp_ff;
      cur_in    = cur_ff;
      prv_in    = prv_ff;
      put_in    = put_ff;
      ue_in     = ue_ff;
      mp_in     = mp_ff;
      mn_in     = mn_ff;
      status_in = status_ff;
      end_in    = end_ff;
      fcnt_in   = fcnt_ff;
      ucnt_in   = ucnt_ff;
      f_we = 1'b0;
      f_wa = {rs, k_ff[IW-1:0]};
      f_wd = f_rd;
      f_ra = {rs, k_ff[IW-1:0]};
      u_we = 1'b0;
      u_wa = {rs, k_ff[IW-1:0]};
      u_wd = u_rd;
      u_ra = {rs, k_ff[IW-1:0]};

      unique case (state_ff)
         S_INIT: begin
            f_we = 1'b1;
            f_wa = {sp_ff, {IW{1'b0}}};
            f_wd = '{lo: 32'd0, hi: space_limit(2'(sp_ff))};
            sp_in = sp_ff + 1'b1;
            if (sp_ff == SP_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            k_in      = '0;
            status_in = ST_OK;
            end_in    = '0;
            rend_in   = sum[31:0];
            if (req_ff.addr_type >= 3'(SPACE_COUNT)) begin
               status_in = ST_UNKNOWN_TYPE;
               state_in  = S_RESP;
            end else if (rel) begin
               if (req_ff.base_address > lim) begin
                  status_in = ST_BAD_RANGE;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_UF_RD;
               end
            end else if (req_ff.range_size == '0 || sum > {2'b0, lim}) begin
               status_in = ST_BAD_RANGE;
               state_in  = S_RESP;
            end else begin
               state_in = S_FS_RD;
            end
         end
         // register: find the free entry that holds the range
         S_FS_RD: begin
            if (k_ff == nf) begin
               status_in = ST_OVERLAP;
               state_in  = S_RESP;
            end else begin
               state_in = S_FS_EV;
            end
         end
         S_FS_EV: begin
            if (f_rd.lo > req_ff.base_address) begin
               status_in = ST_OVERLAP;
               state_in  = S_RESP;
            end else if (rend_ff <= f_rd.hi) begin
               cur_in   = f_rd;
               p_in     = k_ff;
               state_in = S_RG_FREE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_FS_RD;
            end
         end
         S_RG_FREE: begin
            f_wa = {rs, p_ff[IW-1:0]};
            if (nu >= CNT_MAX) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_RESP;
            end else if (cur_ff.lo != req_ff.base_address && cur_ff.hi != rend_ff
                         && nf >= CNT_MAX) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_RESP;
            end else if (cur_ff.lo == req_ff.base_address && cur_ff.hi == rend_ff) begin
               k_in     = p_ff;
               state_in = S_FD_RD;
            end else if (cur_ff.lo == req_ff.base_address) begin
               f_we     = 1'b1;
               f_wd     = '{lo: rend_ff + 32'd1, hi: cur_ff.hi};
               k_in     = '0;
               state_in = S_US_RD;
            end else if (cur_ff.hi == rend_ff) begin
               f_we     = 1'b1;
               f_wd     = '{lo: cur_ff.lo, hi: req_ff.base_address - 32'd1};
               k_in     = '0;
               state_in = S_US_RD;
            end else begin
               f_we     = 1'b1;
               f_wd     = '{lo: cur_ff.lo, hi: req_ff.base_address - 32'd1};
               put_in   = '{lo: rend_ff + 32'd1, hi: cur_ff.hi};
               p_in     = p_ff + 1'b1;
               k_in     = nf;
               state_in = S_FU_RD;
            end
         end
         // free table: remove entry k by shifting the tail down
         S_FD_RD: begin
            f_ra = {rs, kp1[IW-1:0]};
            if (kp1 < {1'b0, nf}) begin
               state_in = S_FD_WR;
            end else begin
               fcnt_in[rs] = nf - 1'b1;
               k_in        = '0;
               state_in    = rel ? S_RESP : S_US_RD;
               if (rel) begin
                  end_in = ue_ff;
               end
            end
         end
         S_FD_WR: begin
            f_we     = 1'b1;
            k_in     = k_ff + 1'b1;
            state_in = S_FD_RD;
         end
         // free table: open a hole at p by shifting the tail up
         S_FU_RD: begin
            f_ra = {rs, km1[IW-1:0]};
            state_in = (k_ff > p_ff) ? S_FU_WR : S_F_PUT;
         end
         S_FU_WR: begin
            f_we     = 1'b1;
            k_in     = km1;
            state_in = S_FU_RD;
         end
         S_F_PUT: begin
            f_we        = 1'b1;
            f_wa        = {rs, p_ff[IW-1:0]};
            f_wd        = put_ff;
            fcnt_in[rs] = nf + 1'b1;
            k_in        = '0;
            state_in    = rel ? S_RESP : S_US_RD;
            if (rel) begin
               end_in = ue_ff;
            end
         end
         // register: find the slot in the used table
         S_US_RD: begin
            if (k_ff == nu) begin
               p_in     = k_ff;
               state_in = S_UU_RD;
            end else begin
               state_in = S_US_EV;
            end
         end
         S_US_EV: begin
            if (u_rd.lo < req_ff.base_address) begin
               k_in     = k_ff + 1'b1;
               state_in = S_US_RD;
            end else begin
               p_in     = k_ff;
               k_in     = nu;
               state_in = S_UU_RD;
            end
         end
         S_UU_RD: begin
            u_ra = {rs, km1[IW-1:0]};
            state_in = (k_ff > p_ff) ? S_UU_WR : S_U_PUT;
         end
         S_UU_WR: begin
            u_we     = 1'b1;
            k_in     = km1;
            state_in = S_UU_RD;
         end
         S_U_PUT: begin
            u_we        = 1'b1;
            u_wa        = {rs, p_ff[IW-1:0]};
            u_wd        = '{lo: req_ff.base_address, hi: rend_ff, owner: req_ff.owner_id};
            ucnt_in[rs] = nu + 1'b1;
            end_in      = rend_ff;
            state_in    = S_RESP;
         end
         // release: find the used entry by its start
         S_UF_RD: begin
            if (k_ff == nu) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               state_in = S_UF_EV;
            end
         end
         S_UF_EV: begin
            if (u_rd.lo == req_ff.base_address) begin
               if (u_rd.owner != req_ff.owner_id) begin
                  status_in = ST_WRONG_OWNER;
                  state_in  = S_RESP;
               end else begin
                  ue_in    = u_rd.hi;
                  p_in     = k_ff;
                  k_in     = '0;
                  state_in = S_FP_RD;
               end
            end else if (u_rd.lo > req_ff.base_address) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_UF_RD;
            end
         end
         // release: locate the free neighbors
         S_FP_RD: begin
            state_in = (k_ff == nf) ? S_RL_DEC : S_FP_EV;
         end
         S_FP_EV: begin
            if (f_rd.lo < req_ff.base_address) begin
               prv_in   = f_rd;
               k_in     = k_ff + 1'b1;
               state_in = S_FP_RD;
            end else begin
               cur_in   = f_rd;
               state_in = S_RL_DEC;
            end
         end
         S_RL_DEC: begin
            mp_in = (k_ff != '0) && (pe_inc == {1'b0, req_ff.base_address});
            mn_in = (k_ff < nf) && ({1'b0, cur_ff.lo} == e_inc);
            put_in = '{lo: req_ff.base_address, hi: ue_ff};
            if (!mp_in && !mn_in && nf >= CNT_MAX) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_RESP;
            end else begin
               // k holds the free position; swap it with the used index
               k_in     = p_ff;
               p_in     = k_ff;
               state_in = S_UD_RD;
            end
         end
         S_UD_RD: begin
            u_ra = {rs, kp1[IW-1:0]};
            if (kp1 < {1'b0, nu}) begin
               state_in = S_UD_WR;
            end else begin
               ucnt_in[rs] = nu - 1'b1;
               state_in    = S_RL_FREE;
            end
         end
         S_UD_WR: begin
            u_we     = 1'b1;
            k_in     = k_ff + 1'b1;
            state_in = S_UD_RD;
         end
         S_RL_FREE: begin
            f_we = 1'b1;
            f_wa = {rs, p_ff[IW-1:0] - 1'b1};
            end_in = ue_ff;
            priority if (mp_ff && mn_ff) begin
               f_wd     = '{lo: prv_ff.lo, hi: cur_ff.hi};
               k_in     = p_ff;
               state_in = S_FD_RD;
            end else if (mp_ff) begin
               f_wd     = '{lo: prv_ff.lo, hi: ue_ff};
               state_in = S_RESP;
            end else if (mn_ff) begin
               f_wa     = {rs, p_ff[IW-1:0]};
               f_wd     = '{lo: req_ff.base_address, hi: cur_ff.hi};
               state_in = S_RESP;
            end else begin
               f_we     = 1'b0;
               k_in     = nf;
               state_in = S_FU_RD;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = '{status: status_ff,
                        range_end: (status_ff == ST_OK) ? end_ff : 32'd0};

endmodule

### hw/rtl/ara_checker.sv
module ara_checker
   import ara_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // one word in flight: no new request while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("not busy after accepting a request");

   a_fail_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.range_end == 32'd0)
      else $error("failed result with nonzero end");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("activity right after reset");

endmodule

bind address_range_allocator ara_checker u_ara_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
